>>> hw/rtl/timer_event_alarm_table_unit_defines.svh
// Assertion shorthands shared by the alarm table RTL.
// Both expect signals named clk and arst_n in the using module.
`ifndef TIMER_EVENT_ALARM_TABLE_UNIT_DEFINES_SVH
`define TIMER_EVENT_ALARM_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication.
`define TEAT_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define TEAT_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/teat_pkg.sv
package teat_pkg;

	// request codes
	localparam logic [2:0] REQ_TICK = 3'd0;
	localparam logic [2:0] REQ_MONITOR = 3'd1;
	localparam logic [2:0] REQ_ADD = 3'd2;
	localparam logic [2:0] REQ_KILL = 3'd3;
	localparam logic [2:0] REQ_LOAD = 3'd4;

	// response status codes
	localparam logic [2:0] STAT_NONE = 3'd0;
	localparam logic [2:0] STAT_ADDED = 3'd1;
	localparam logic [2:0] STAT_FULL = 3'd2;
	localparam logic [2:0] STAT_KILLED = 3'd3;
	localparam logic [2:0] STAT_NOTFOUND = 3'd4;
	localparam logic [2:0] STAT_FIRED = 3'd5;

	typedef enum logic [1:0] {
		PH_CHECK = 2'd0,
		PH_TEST = 2'd1,
		PH_ADVANCE = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD_SCAN,
		ST_KILL_RD,
		ST_KILL_CHK,
		ST_MON_RD,
		ST_MON_WR,
		ST_DONE
	} state_t;

	// one entry record held in the store
	typedef struct packed {
		logic [15:0] tag;
		logic [31:0] expiry;
		logic [7:0] repeats;
		logic [15:0] reload;
	} entry_rec_t;

	// store port controls
	typedef struct packed {
		logic rd;
		logic wr;
	} ram_ctl_t;

endpackage

>>> hw/rtl/teat_entry_store.sv
module teat_entry_store #(
	parameter int ENTRIES = 8
) (
	input logic clk,
	input logic arst_n,
	input teat_pkg::ram_ctl_t ctl,
	input logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] addr,
	input teat_pkg::entry_rec_t wr_rec,
	output teat_pkg::entry_rec_t rd_rec
);
	teat_pkg::entry_rec_t mem [ENTRIES];
	teat_pkg::entry_rec_t rd_data_q;
	logic [ENTRIES-1:0] written_q;
	logic rd_written_q;

	// single port: one read or one write per cycle, read data registered
	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem[addr] <= wr_rec;
		end
		if (ctl.rd) begin
			rd_data_q <= mem[addr];
		end
	end

	// tags reset to zero: track which entries were ever written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			rd_written_q <= 1'b0;
		end else begin
			if (ctl.wr) begin
				written_q[addr] <= 1'b1;
			end
			if (ctl.rd) begin
				rd_written_q <= written_q[addr];
			end
		end
	end

	always_comb begin
		rd_rec = rd_data_q;
		if (!rd_written_q) begin
			rd_rec.tag = '0;
		end
	end

endmodule

>>> hw/rtl/timer_event_alarm_table_unit.sv
// Channel  | Handshake           | Payload
// ---------+---------------------+---------------------------------------------
// request  | req_valid/req_ready | req_type, tag, expire_time, repeat_count,
//          |                     | reload_interval, has_start_action,
//          |                     | has_stop_action, time_value
// response | rsp_valid/rsp_ready | status, event_tag, start_notice, seconds_now
//
// One request transaction gives exactly one response transaction.
// Sequence: tick, load, unknown codes and the check/advance monitor phases go
// straight from idle to done; monitor test takes a store read, then a
// read-modify-write; add walks the active bits; kill reads one stored tag at a
// time through the single store port, alternating a read and a check state.
// Reset (arst_n low) clears the table control bits, scan state, counter and
// prescaler at once; no clearing pass is needed.
// A new request is taken while a response still waits; the block then holds
// the next result until rsp_ready frees the response register.
`include "timer_event_alarm_table_unit_defines.svh"

module timer_event_alarm_table_unit #(
	parameter int ENTRIES = 8
) (
	input logic clk,
	input logic arst_n,

	input logic req_valid,
	output logic req_ready,
	input logic [2:0] req_type,
	input logic [15:0] tag,
	input logic [31:0] expire_time,
	input logic [7:0] repeat_count,
	input logic [15:0] reload_interval,
	input logic has_start_action,
	input logic has_stop_action,
	input logic [31:0] time_value,

	output logic rsp_valid,
	input logic rsp_ready,
	output logic [2:0] status,
	output logic [15:0] event_tag,
	output logic start_notice,
	output logic [31:0] seconds_now
);
	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

	teat_pkg::state_t state_q, state_d;
	teat_pkg::phase_t phase_q;
	logic [IW-1:0] scan_idx_q;
	logic [IW-1:0] srch_idx_q;
	logic [31:0] seconds_q;
	logic parity_q;

	// control bits of the table, reset to zero
	logic [ENTRIES-1:0] active_q;
	logic [ENTRIES-1:0] stop_q;

	// latched request fields
	logic [15:0] req_tag_q;
	logic [31:0] req_expiry_q;
	logic [7:0] req_repeats_q;
	logic [15:0] req_reload_q;
	logic req_start_q;
	logic req_stop_q;

	// result being built
	logic [2:0] res_status_q;
	logic [15:0] res_tag_q;
	logic res_notice_q;

	// response register
	logic rsp_valid_q;
	logic [2:0] rsp_status_q;
	logic [15:0] rsp_tag_q;
	logic rsp_notice_q;
	logic [31:0] rsp_seconds_q;

	teat_pkg::ram_ctl_t ram_ctl;
	logic [IW-1:0] ram_addr;
	teat_pkg::entry_rec_t wr_rec;
	teat_pkg::entry_rec_t rd_rec;

	logic accept;
	logic rsp_free;
	logic out_load;
	logic srch_last;
	logic fire;
	logic kill_hit;

	assign accept = req_valid && req_ready;
	assign rsp_free = !rsp_valid_q || rsp_ready;
	assign srch_last = (srch_idx_q == LAST_IDX);
	assign kill_hit = (rd_rec.tag == req_tag_q);
	// test phase: expired and armed with a stop action
	assign fire = (seconds_q >= rd_rec.expiry) && stop_q[scan_idx_q];

	teat_entry_store #(
		.ENTRIES(ENTRIES)
	) u_store (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ram_ctl),
		.addr(ram_addr),
		.wr_rec(wr_rec),
		.rd_rec(rd_rec)
	);

	// ---------------- sequencer: next state ----------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			teat_pkg::ST_IDLE: begin
				if (req_valid) begin
					case (req_type)
						teat_pkg::REQ_ADD: state_d = teat_pkg::ST_ADD_SCAN;
						teat_pkg::REQ_KILL: state_d = teat_pkg::ST_KILL_RD;
						teat_pkg::REQ_MONITOR: begin
							state_d = (phase_q == teat_pkg::PH_TEST) ?
								teat_pkg::ST_MON_RD : teat_pkg::ST_DONE;
						end
						default: state_d = teat_pkg::ST_DONE;
					endcase
				end
			end
			teat_pkg::ST_ADD_SCAN: begin
				if (!active_q[srch_idx_q] || srch_last) begin
					state_d = teat_pkg::ST_DONE;
				end
			end
			teat_pkg::ST_KILL_RD: state_d = teat_pkg::ST_KILL_CHK;
			teat_pkg::ST_KILL_CHK: begin
				state_d = (kill_hit || srch_last) ? teat_pkg::ST_DONE : teat_pkg::ST_KILL_RD;
			end
			teat_pkg::ST_MON_RD: state_d = teat_pkg::ST_MON_WR;
			teat_pkg::ST_MON_WR: state_d = teat_pkg::ST_DONE;
			teat_pkg::ST_DONE: begin
				if (rsp_free) begin
					state_d = teat_pkg::ST_IDLE;
				end
			end
			default: state_d = teat_pkg::ST_IDLE;
		endcase
	end

	// ---------------- sequencer: outputs ----------------
	always_comb begin
		req_ready = 1'b0;
		out_load = 1'b0;
		ram_ctl = '0;
		ram_addr = srch_idx_q;
		wr_rec.tag = req_tag_q;
		wr_rec.expiry = req_expiry_q;
		wr_rec.repeats = req_repeats_q;
		wr_rec.reload = req_reload_q;
		case (state_q)
			teat_pkg::ST_IDLE: req_ready = 1'b1;
			teat_pkg::ST_ADD_SCAN: ram_ctl.wr = !active_q[srch_idx_q];
			teat_pkg::ST_KILL_RD: ram_ctl.rd = 1'b1;
			teat_pkg::ST_MON_RD: begin
				ram_ctl.rd = 1'b1;
				ram_addr = scan_idx_q;
			end
			teat_pkg::ST_MON_WR: begin
				// reload in place; tag and interval are written back unchanged
				ram_addr = scan_idx_q;
				ram_ctl.wr = fire && (rd_rec.repeats != 8'd0);
				wr_rec.tag = rd_rec.tag;
				wr_rec.expiry = seconds_q + {16'd0, rd_rec.reload};
				wr_rec.repeats = rd_rec.repeats - 8'd1;
				wr_rec.reload = rd_rec.reload;
			end
			teat_pkg::ST_DONE: out_load = rsp_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= teat_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ---------------- request latch and result ----------------
	always_ff @(posedge clk) begin
		if (accept) begin
			req_tag_q <= tag;
			req_expiry_q <= expire_time;
			req_repeats_q <= repeat_count;
			req_reload_q <= reload_interval;
			req_start_q <= has_start_action;
			req_stop_q <= has_stop_action;
			res_status_q <= teat_pkg::STAT_NONE;
			res_tag_q <= '0;
			res_notice_q <= 1'b0;
			srch_idx_q <= '0;
		end
		case (state_q)
			teat_pkg::ST_ADD_SCAN: begin
				if (!active_q[srch_idx_q]) begin
					res_status_q <= teat_pkg::STAT_ADDED;
					res_tag_q <= req_tag_q;
					res_notice_q <= req_start_q;
				end else if (srch_last) begin
					res_status_q <= teat_pkg::STAT_FULL;
					res_tag_q <= req_tag_q;
				end else begin
					srch_idx_q <= srch_idx_q + 1'b1;
				end
			end
			teat_pkg::ST_KILL_CHK: begin
				if (kill_hit) begin
					res_status_q <= teat_pkg::STAT_KILLED;
					res_tag_q <= req_tag_q;
				end else if (srch_last) begin
					res_status_q <= teat_pkg::STAT_NOTFOUND;
					res_tag_q <= req_tag_q;
				end else begin
					srch_idx_q <= srch_idx_q + 1'b1;
				end
			end
			teat_pkg::ST_MON_WR: begin
				if (fire) begin
					res_status_q <= teat_pkg::STAT_FIRED;
					res_tag_q <= rd_rec.tag;
				end
			end
			default: ;
		endcase
	end

	// ---------------- table control, scan and clock ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			stop_q <= '0;
			phase_q <= teat_pkg::PH_CHECK;
			scan_idx_q <= '0;
			seconds_q <= '0;
			parity_q <= 1'b0;
		end else begin
			if (accept) begin
				case (req_type)
					teat_pkg::REQ_TICK: begin
						// half-rate prescaler
						if (!parity_q) begin
							seconds_q <= seconds_q + 32'd1;
						end
						parity_q <= !parity_q;
					end
					teat_pkg::REQ_LOAD: seconds_q <= time_value;
					teat_pkg::REQ_MONITOR: begin
						case (phase_q)
							teat_pkg::PH_CHECK: begin
								phase_q <= active_q[scan_idx_q] ?
									teat_pkg::PH_TEST : teat_pkg::PH_ADVANCE;
							end
							teat_pkg::PH_TEST: ; // handled in ST_MON_WR
							default: begin
								scan_idx_q <= (scan_idx_q == LAST_IDX) ?
									'0 : scan_idx_q + 1'b1;
								phase_q <= teat_pkg::PH_CHECK;
							end
						endcase
					end
					default: ;
				endcase
			end
			case (state_q)
				teat_pkg::ST_ADD_SCAN: begin
					if (!active_q[srch_idx_q]) begin
						active_q[srch_idx_q] <= 1'b1;
						stop_q[srch_idx_q] <= req_stop_q;
					end
				end
				teat_pkg::ST_KILL_CHK: begin
					// matches any slot's tag, active or not
					if (kill_hit) begin
						active_q[srch_idx_q] <= 1'b0;
						stop_q[srch_idx_q] <= 1'b0;
					end
				end
				teat_pkg::ST_MON_WR: begin
					if (fire && (rd_rec.repeats == 8'd0)) begin
						active_q[scan_idx_q] <= 1'b0;
					end
					phase_q <= teat_pkg::PH_ADVANCE;
				end
				default: ;
			endcase
		end
	end

	// ---------------- response register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rsp_status_q <= res_status_q;
			rsp_tag_q <= res_tag_q;
			rsp_notice_q <= res_notice_q;
			rsp_seconds_q <= seconds_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign status = rsp_status_q;
	assign event_tag = rsp_tag_q;
	assign start_notice = rsp_notice_q;
	assign seconds_now = rsp_seconds_q;

	// ---------------- checks ----------------
	`TEAT_ASSERT_NXT(a_accept_goes_busy, accept, state_q != teat_pkg::ST_IDLE, "request taken but sequencer stayed idle")
	`TEAT_ASSERT_IMP(a_fire_only_active, (state_q == teat_pkg::ST_MON_WR) && fire, active_q[scan_idx_q], "entry fired from an inactive slot")
	`TEAT_ASSERT_NXT(a_done_loads_rsp, (state_q == teat_pkg::ST_DONE) && rsp_free, rsp_valid && (state_q == teat_pkg::ST_IDLE), "finished result not presented")

endmodule

>>> sim/timer_event_alarm_table_checker.sv
module timer_event_alarm_table_checker #(
	parameter int ENTRIES = 8
) (
	input logic clk,
	input logic arst_n,

	input logic req_valid,
	input logic req_ready,
	input logic [2:0] req_type,
	input logic [15:0] tag,
	input logic [31:0] expire_time,
	input logic [7:0] repeat_count,
	input logic [15:0] reload_interval,
	input logic has_start_action,
	input logic has_stop_action,
	input logic [31:0] time_value,

	input logic rsp_valid,
	input logic rsp_ready,
	input logic [2:0] status,
	input logic [15:0] event_tag,
	input logic start_notice,
	input logic [31:0] seconds_now,

	output int mismatches,
	output int pending,
	output int responses,
	output int added_seen,
	output int full_seen,
	output int killed_seen,
	output int notfound_seen,
	output int fired_seen
);
	typedef struct packed {
		logic [2:0] status;
		logic [15:0] tag;
		logic notice;
		logic [31:0] seconds;
	} alarm_result_t;

	// shadow of the alarm table
	logic slot_active [ENTRIES];
	logic slot_stop [ENTRIES];
	logic [15:0] slot_tag [ENTRIES];
	logic [31:0] slot_expiry [ENTRIES];
	logic [7:0] slot_repeats [ENTRIES];
	logic [15:0] slot_reload [ENTRIES];
	int scan_slot;
	teat_pkg::phase_t scan_ph;
	logic [31:0] clock_secs;
	logic half_parity;

	alarm_result_t alarm_results_q[$];
	int mismatch_count, response_count;
	int count_added, count_full, count_killed, count_notfound, count_fired;

	assign mismatches = mismatch_count;
	assign pending = alarm_results_q.size();
	assign responses = response_count;
	assign added_seen = count_added;
	assign full_seen = count_full;
	assign killed_seen = count_killed;
	assign notfound_seen = count_notfound;
	assign fired_seen = count_fired;

	task automatic clear_table();
		for (int k = 0; k < ENTRIES; k++) begin
			slot_active[k] = 1'b0;
			slot_stop[k] = 1'b0;
			slot_tag[k] = '0;
			slot_expiry[k] = '0;
			slot_repeats[k] = '0;
			slot_reload[k] = '0;
		end
		scan_slot = 0;
		scan_ph = teat_pkg::PH_CHECK;
		clock_secs = '0;
		half_parity = 1'b0;
	endtask

	// one scan step: check active, test expiry, advance index
	task automatic scan_step(inout alarm_result_t r);
		case (scan_ph)
			teat_pkg::PH_CHECK: begin
				scan_ph = slot_active[scan_slot] ? teat_pkg::PH_TEST : teat_pkg::PH_ADVANCE;
			end
			teat_pkg::PH_TEST: begin
				// active bit not rechecked; a killed slot has no stop action
				if (clock_secs >= slot_expiry[scan_slot] && slot_stop[scan_slot]) begin
					r.status = teat_pkg::STAT_FIRED;
					r.tag = slot_tag[scan_slot];
					if (slot_repeats[scan_slot] != 8'd0) begin
						slot_repeats[scan_slot] = slot_repeats[scan_slot] - 8'd1;
						slot_expiry[scan_slot] = clock_secs + 32'(slot_reload[scan_slot]);
					end else begin
						slot_active[scan_slot] = 1'b0;
					end
				end
				scan_ph = teat_pkg::PH_ADVANCE;
			end
			default: begin
				scan_slot = (scan_slot + 1) % ENTRIES;
				scan_ph = teat_pkg::PH_CHECK;
			end
		endcase
	endtask

	task automatic predict_alarm(output alarm_result_t r);
		bit found;
		r = '0;
		r.status = teat_pkg::STAT_NONE;
		found = 1'b0;
		case (req_type)
			teat_pkg::REQ_TICK: begin
				if (!half_parity)
					clock_secs = clock_secs + 32'd1;
				half_parity = ~half_parity;
			end
			teat_pkg::REQ_MONITOR: scan_step(r);
			teat_pkg::REQ_ADD: begin
				r.status = teat_pkg::STAT_FULL;
				r.tag = tag;
				for (int k = 0; k < ENTRIES && !found; k++) begin
					if (!slot_active[k]) begin
						found = 1'b1;
						slot_active[k] = 1'b1;
						slot_stop[k] = has_stop_action;
						slot_tag[k] = tag;
						slot_expiry[k] = expire_time;
						slot_repeats[k] = repeat_count;
						slot_reload[k] = reload_interval;
						r.status = teat_pkg::STAT_ADDED;
						r.notice = has_start_action;
					end
				end
			end
			teat_pkg::REQ_KILL: begin
				// lowest slot with that tag, live or not
				r.status = teat_pkg::STAT_NOTFOUND;
				r.tag = tag;
				for (int k = 0; k < ENTRIES && !found; k++) begin
					if (slot_tag[k] == tag) begin
						found = 1'b1;
						slot_active[k] = 1'b0;
						slot_stop[k] = 1'b0;
						r.status = teat_pkg::STAT_KILLED;
					end
				end
			end
			teat_pkg::REQ_LOAD: clock_secs = time_value;
			default: ;
		endcase
		r.seconds = clock_secs;
	endtask

	task automatic check_response();
		alarm_result_t want, got;
		got = '{status, event_tag, start_notice, seconds_now};
		response_count++;
		case (got.status)
			teat_pkg::STAT_ADDED: count_added++;
			teat_pkg::STAT_FULL: count_full++;
			teat_pkg::STAT_KILLED: count_killed++;
			teat_pkg::STAT_NOTFOUND: count_notfound++;
			teat_pkg::STAT_FIRED: count_fired++;
			default: ;
		endcase
		if (alarm_results_q.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("response %0d arrived with no request outstanding", response_count);
		end else begin
			want = alarm_results_q.pop_front();
			if (got.status !== want.status || got.tag !== want.tag ||
					got.notice !== want.notice || got.seconds !== want.seconds) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display({"response %0d (exp/got): status %0d/%0d tag %h/%h ",
						"start %b/%b seconds %h/%h"}, response_count,
						want.status, got.status, want.tag, got.tag,
						want.notice, got.notice, want.seconds, got.seconds);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_table();
			alarm_results_q.delete();
			mismatch_count = 0;
			response_count = 0;
			count_added = 0;
			count_full = 0;
			count_killed = 0;
			count_notfound = 0;
			count_fired = 0;
		end else begin
			alarm_result_t next_result;
			// retire first so a response can never match the request taken this edge
			if (rsp_valid && rsp_ready)
				check_response();
			if (req_valid && req_ready) begin
				predict_alarm(next_result);
				alarm_results_q.push_back(next_result);
			end
		end
	end

endmodule

>>> sim/testbench.sv
module testbench;
	localparam int ENTRIES = 8;
	localparam int RANDOM_ITEMS = 1300;
	// no idling on either side for the tail of the run
	localparam int CALM_ITEMS = 150;
	// worst case per transaction is a request gap plus a full kill walk plus a stall
	localparam int CYCLE_LIMIT = 400000;
	// longest request is a kill that walks every slot; leave margin
	localparam int DRAIN_CYCLES = 40;
	// request codes the block does not decode
	localparam logic [2:0] REQ_BAD_FIRST = 3'd5;
	localparam logic [2:0] REQ_BAD_LAST = 3'd7;

	logic clk;
	logic arst_n;

	logic req_valid;
	logic req_ready;
	logic [2:0] req_type;
	logic [15:0] tag;
	logic [31:0] expire_time;
	logic [7:0] repeat_count;
	logic [15:0] reload_interval;
	logic has_start_action;
	logic has_stop_action;
	logic [31:0] time_value;

	logic rsp_valid;
	logic rsp_ready;
	logic [2:0] status;
	logic [15:0] event_tag;
	logic start_notice;
	logic [31:0] seconds_now;

	int mismatches, pending, responses;
	int added_seen, full_seen, killed_seen, notfound_seen, fired_seen;

	int cycle_count;
	int sent_count;
	int counted_items;
	bit calm;
	int stall_left;
	// tags of recent adds, so kills mostly hit something live
	logic [15:0] live_tags[$];

	timer_event_alarm_table_unit #(
		.ENTRIES(ENTRIES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_type(req_type),
		.tag(tag),
		.expire_time(expire_time),
		.repeat_count(repeat_count),
		.reload_interval(reload_interval),
		.has_start_action(has_start_action),
		.has_stop_action(has_stop_action),
		.time_value(time_value),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.status(status),
		.event_tag(event_tag),
		.start_notice(start_notice),
		.seconds_now(seconds_now)
	);

	// watches both channels, predicts every response and compares
	timer_event_alarm_table_checker #(
		.ENTRIES(ENTRIES)
	) alarm_checker (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_type(req_type),
		.tag(tag),
		.expire_time(expire_time),
		.repeat_count(repeat_count),
		.reload_interval(reload_interval),
		.has_start_action(has_start_action),
		.has_stop_action(has_stop_action),
		.time_value(time_value),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.status(status),
		.event_tag(event_tag),
		.start_notice(start_notice),
		.seconds_now(seconds_now),
		.mismatches(mismatches),
		.pending(pending),
		.responses(responses),
		.added_seen(added_seen),
		.full_seen(full_seen),
		.killed_seen(killed_seen),
		.notfound_seen(notfound_seen),
		.fired_seen(fired_seen)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// watchdog: a hung handshake ends the run as a failure
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d responses still due", cycle_count, pending);
			$display("Mismatches found");
			$finish;
		end
	end

	// response side: random stall bursts of random length, none once calm.
	// Stalls run independent of rsp_valid so they land on every phase.
	initial begin
		rsp_ready = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (!arst_n) begin
				rsp_ready = 1'b0;
			end else if (stall_left > 0) begin
				rsp_ready = 1'b0;
				stall_left--;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				rsp_ready = 1'b0;
				stall_left = $urandom_range(1, 11) - 1;
			end else begin
				rsp_ready = 1'b1;
			end
		end
	end

	// One request transaction. Called right after a falling edge; returns
	// right after the falling edge that follows acceptance, with valid low
	// unless the next call raises it again in the same step.
	task automatic send_request(input logic [2:0] kind, input logic [15:0] t,
			input logic [31:0] expiry, input logic [7:0] repeats,
			input logic [15:0] reload, input logic start_act, input logic stop_act,
			input logic [31:0] load_val);
		int gap;
		if (!calm && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 11);
			req_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid = 1'b1;
		req_type = kind;
		tag = t;
		expire_time = expiry;
		repeat_count = repeats;
		reload_interval = reload;
		has_start_action = start_act;
		has_stop_action = stop_act;
		time_value = load_val;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		@(negedge clk);
		req_valid = 1'b0;
		sent_count++;
	endtask

	// Small corner sequence: kills on an empty table (a never-set tag
	// matches 0), prescaler parity across a load, counter wrap, filling the
	// table to full, a firing entry, a kill between the check and test
	// phases of a scan, and undecoded request codes.
	task automatic run_directed();
		send_request(teat_pkg::REQ_KILL, 16'h0000, '0, '0, '0, 1'b0, 1'b0, '0);
		send_request(teat_pkg::REQ_KILL, 16'hFFFF, '0, '0, '0, 1'b0, 1'b0, '0);
		repeat (3) send_request(teat_pkg::REQ_TICK, '0, '0, '0, '0, 1'b0, 1'b0, '0);
		// parity is odd now and the load keeps it: first tick holds, second wraps
		send_request(teat_pkg::REQ_LOAD, '0, '0, '0, '0, 1'b0, 1'b0, 32'hFFFF_FFFF);
		repeat (2) send_request(teat_pkg::REQ_TICK, '0, '0, '0, '0, 1'b0, 1'b0, '0);
		send_request(teat_pkg::REQ_ADD, 16'hFFFF, 32'h0, 8'hFF, 16'hFFFF, 1'b1, 1'b1, '0);
		send_request(teat_pkg::REQ_ADD, 16'h0001, 32'h0, 8'h00, 16'h0000, 1'b0, 1'b1, '0);
		send_request(teat_pkg::REQ_ADD, 16'h0000, 32'hFFFF_FFFF, 8'h00, 16'h0000,
			1'b1, 1'b0, '0);
		for (int k = 2; k < ENTRIES; k++)
			send_request(teat_pkg::REQ_ADD, 16'(k), 32'h1, 8'h01, 16'h0005, k[0], 1'b1, '0);
		send_request(teat_pkg::REQ_ADD, 16'h00AA, 32'h5, 8'h02, 16'h0003, 1'b1, 1'b1, '0);
		// slot 0: check, test (fires at second 0), advance
		repeat (3) send_request(teat_pkg::REQ_MONITOR, '0, '0, '0, '0, 1'b0, 1'b0, '0);
		// slot 1 killed after its check phase: the test phase must do nothing
		send_request(teat_pkg::REQ_MONITOR, '0, '0, '0, '0, 1'b0, 1'b0, '0);
		send_request(teat_pkg::REQ_KILL, 16'h0001, '0, '0, '0, 1'b0, 1'b0, '0);
		send_request(teat_pkg::REQ_MONITOR, '0, '0, '0, '0, 1'b0, 1'b0, '0);
		send_request(REQ_BAD_FIRST, 16'h1234, '1, '1, '1, 1'b1, 1'b1, '1);
		send_request(REQ_BAD_LAST, 16'h4321, '1, '1, '1, 1'b1, 1'b1, '1);
	endtask

	// Mostly meaningful traffic: small tags and times near the counter so
	// alarms fire and reload, with full-range values mixed in. Fields a
	// request does not use carry random noise.
	task automatic send_random();
		logic [2:0] kind;
		logic [15:0] t, reload;
		logic [31:0] expiry, load_val;
		logic [7:0] repeats;
		logic start_act, stop_act;
		int pick, idx;
		t = 16'($urandom());
		expiry = $urandom();
		repeats = 8'($urandom());
		reload = 16'($urandom());
		start_act = 1'($urandom());
		stop_act = 1'($urandom());
		load_val = $urandom();
		pick = $urandom_range(0, 99);
		if (pick < 22) begin
			kind = teat_pkg::REQ_TICK;
		end else if (pick < 58) begin
			kind = teat_pkg::REQ_MONITOR;
		end else if (pick < 72) begin
			kind = teat_pkg::REQ_ADD;
			if ($urandom_range(0, 9) < 8)
				t = 16'($urandom_range(0, 9));
			pick = $urandom_range(0, 99);
			if (pick < 55)
				expiry = $urandom_range(0, 80);
			else if (pick < 70)
				expiry = 32'hFFFF_FFFF - $urandom_range(0, 255);
			pick = $urandom_range(0, 99);
			if (pick < 70)
				repeats = 8'($urandom_range(0, 3));
			else if (pick < 95)
				repeats = 8'($urandom_range(0, 255));
			else
				repeats = 8'hFF;
			if ($urandom_range(0, 9) < 6)
				reload = 16'($urandom_range(0, 30));
			stop_act = ($urandom_range(0, 99) < 85);
			live_tags.push_back(t);
			if (live_tags.size() > 16)
				void'(live_tags.pop_front());
		end else if (pick < 84) begin
			kind = teat_pkg::REQ_KILL;
			pick = $urandom_range(0, 99);
			if (pick < 60 && live_tags.size() > 0) begin
				idx = $urandom_range(0, live_tags.size() - 1);
				t = live_tags[idx];
				live_tags.delete(idx);
			end else if (pick < 85) begin
				t = 16'($urandom_range(0, 9));
			end
		end else if (pick < 94) begin
			kind = teat_pkg::REQ_LOAD;
			pick = $urandom_range(0, 99);
			if (pick < 60)
				load_val = $urandom_range(0, 60);
			else if (pick < 75)
				load_val = 32'hFFFF_FFFF - $urandom_range(0, 40);
		end else begin
			kind = 3'($urandom_range(REQ_BAD_FIRST, REQ_BAD_LAST));
		end
		counted_items++;
		send_request(kind, t, expiry, repeats, reload, start_act, stop_act, load_val);
	endtask

	initial begin
		int directed_count;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_type = teat_pkg::REQ_TICK;
		tag = '0;
		expire_time = '0;
		repeat_count = '0;
		reload_interval = '0;
		has_start_action = 1'b0;
		has_stop_action = 1'b0;
		time_value = '0;
		calm = 1'b0;
		cycle_count = 0;
		sent_count = 0;
		counted_items = 0;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		run_directed();
		directed_count = sent_count;

		while (counted_items < RANDOM_ITEMS) begin
			if (counted_items >= RANDOM_ITEMS - CALM_ITEMS)
				calm = 1'b1;
			send_random();
		end

		// all requests taken; let the last responses drain
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("%0d request transactions (%0d directed), %0d responses checked",
			sent_count, directed_count, responses);
		$display("outcomes: %0d added, %0d table full, %0d killed, %0d tag misses, %0d fired",
			added_seen, full_seen, killed_seen, notfound_seen, fired_seen);
		if (mismatches == 0 && pending == 0) begin
			$display("No mismatches found");
		end else begin
			$display("%0d bad responses, %0d responses never arrived", mismatches, pending);
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
